@@ design/bmhq_pkg.sv @@
// Package for the binary max-heap priority queue.
// Holds the shared constants, status codes and the controller/datapath structs.
// No dependencies.
package bmhq_pkg;

   // Default number of heap entries and fixed field widths.
   localparam int BMHQ_CAPACITY = 64;
   localparam int DATA_W        = 32;
   localparam int COUNT_OUT_W   = 7;

   // Status code reported with every response.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Which heap index the memory read port addresses.
   typedef enum logic [1:0] {
      RD_PARENT = 2'd0,
      RD_LAST   = 2'd1,
      RD_LEFT   = 2'd2,
      RD_RIGHT  = 2'd3
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;     // latch the incoming request
      logic       do_insert;  // grow the heap, hole at the old count
      logic       do_remove;  // shrink the heap by one
      logic       set_full;   // report insert refused
      logic       set_empty;  // report remove refused
      logic       rd_en;      // issue a memory read
      rd_sel_type rd_sel;     // read address select
      logic       wr_val;     // write the moving value at the hole
      logic       up_move;    // move the parent down into the hole
      logic       load_last;  // take the last entry as the moving value
      logic       cap_left;   // capture the left child value
      logic       down_move;  // move the chosen child up into the hole
      logic       rsp_load;   // load the response register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_remove;  // latched command is remove
      logic full;       // heap holds its capacity
      logic empty;      // heap holds nothing
      logic last_one;   // heap holds exactly one entry
      logic at_root;    // hole is at the root
      logic up_gt;      // moving value beats its parent
      logic left_ok;    // hole has a left child
      logic right_ok;   // hole has a right child
      logic child_gt;   // a child beats the moving value
      logic out_free;   // response register can take a new response
   } dp_stat_type;

endpackage

@@ design/bmhq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the heap entry store.
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bmhq_ctrl.sv @@
// Controller state machine of the binary max-heap priority queue.
// Depends on bmhq_pkg for the command and status structs.
module bmhq_ctrl
   import bmhq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DISPATCH = 9'b000000010,
      S_UP_CHK   = 9'b000000100,
      S_UP_WAIT  = 9'b000001000,
      S_DN_LOAD  = 9'b000010000,
      S_DN_CHK   = 9'b000100000,
      S_DN_L     = 9'b001000000,
      S_DN_R     = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!stat.is_remove) begin
               if (stat.full) begin
                  cmd.set_full = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  cmd.do_insert = 1'b1;
                  state_in      = S_UP_CHK;
               end
            end else if (stat.empty) begin
               cmd.set_empty = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.do_remove = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_LAST;
               state_in      = stat.last_one ? S_DONE : S_DN_LOAD;
            end
         end
         S_UP_CHK: begin
            if (stat.at_root) begin
               cmd.wr_val = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_WAIT;
            end
         end
         S_UP_WAIT: begin
            if (stat.up_gt) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_CHK;
            end else begin
               cmd.wr_val = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DN_LOAD: begin
            cmd.load_last = 1'b1;
            state_in      = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (!stat.left_ok) begin
               cmd.wr_val = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_L;
            end
         end
         S_DN_L: begin
            cmd.cap_left = 1'b1;
            if (stat.right_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_RIGHT;
            end
            state_in = S_DN_R;
         end
         S_DN_R: begin
            if (stat.child_gt) begin
               cmd.down_move = 1'b1;
               state_in      = S_DN_CHK;
            end else begin
               cmd.wr_val = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted request is always decoded in the following cycle.
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DISPATCH))
      else $error("accepted request not dispatched");

   // A finished response waits while the response register is occupied.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !stat.out_free) |=> (state_ff == S_DONE))
      else $error("response dropped while output busy");

   // The sift-up walk never moves past the root.
   a_up_not_root: assert property (@(posedge clock) disable iff (reset)
      cmd.up_move |-> !stat.at_root)
      else $error("sift-up move at root");

endmodule

@@ design/bmhq_dp.sv @@
// Datapath of the binary max-heap priority queue: entry store, hole index,
// moving value, compares and the response register.
// Depends on bmhq_pkg and bmhq_ram.
module bmhq_dp
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = BMHQ_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   input  logic                     req_command,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_top_value,
   output logic [COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic [1:0]               rsp_status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = AW + 2;

   // Request and walk state.
   logic                     is_remove_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [AW-1:0]            pos_ff;
   logic [CW-1:0]            count_ff;
   logic signed [DATA_W-1:0] left_val_ff;
   logic                     right_ok_ff;
   logic signed [DATA_W-1:0] top_ff;
   status_type               status_ff;

   // Response register.
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] out_top_ff;
   logic [COUNT_OUT_W-1:0]   out_count_ff;
   logic                     out_empty_ff;
   status_type               out_status_ff;

   // Memory port signals.
   logic [AW-1:0]            rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] rd_val;
   logic                     wr_en;
   logic signed [DATA_W-1:0] wr_data;

   // Index arithmetic and compare results.
   logic [AW-1:0]            pos_m1;
   logic [AW-1:0]            parent_idx;
   logic [AW-1:0]            last_idx;
   logic [LW-1:0]            left_idx;
   logic [LW-1:0]            right_idx;
   logic                     left_gt;
   logic signed [DATA_W-1:0] best_val;
   logic                     right_gt;
   logic signed [DATA_W-1:0] child_val;
   logic [AW-1:0]            child_idx;

   // Heap neighbors of the hole.
   always_comb begin
      pos_m1     = pos_ff - AW'(1);
      parent_idx = pos_m1 >> 1;
      last_idx   = AW'(count_ff - CW'(1));
      left_idx   = LW'({pos_ff, 1'b1});
      right_idx  = left_idx + LW'(1);
   end

   // Read address select.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_PARENT: rd_addr = parent_idx;
         RD_LAST:   rd_addr = last_idx;
         RD_LEFT:   rd_addr = left_idx[AW-1:0];
         RD_RIGHT:  rd_addr = right_idx[AW-1:0];
         default:   rd_addr = parent_idx;
      endcase
   end

   assign rd_val = $signed(rd_data);

   // Child choice: left wins a strict compare with the moving value, right
   // must strictly beat the larger of the two.
   always_comb begin
      left_gt   = left_val_ff > val_ff;
      best_val  = left_gt ? left_val_ff : val_ff;
      right_gt  = right_ok_ff && (rd_val > best_val);
      child_val = right_gt ? rd_val : left_val_ff;
      child_idx = right_gt ? right_idx[AW-1:0] : left_idx[AW-1:0];
   end

   // Write port: the hole always receives the write.
   always_comb begin
      wr_en = cmd.wr_val || cmd.up_move || cmd.down_move;
      priority if (cmd.wr_val) begin
         wr_data = val_ff;
      end else if (cmd.up_move) begin
         wr_data = rd_val;
      end else begin
         wr_data = child_val;
      end
   end

   bmhq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status toward the controller.
   always_comb begin
      stat.is_remove = is_remove_ff;
      stat.full      = count_ff == CW'(CAPACITY);
      stat.empty     = count_ff == '0;
      stat.last_one  = count_ff == CW'(1);
      stat.at_root   = pos_ff == '0;
      stat.up_gt     = val_ff > rd_val;
      stat.left_ok   = left_idx < LW'(count_ff);
      stat.right_ok  = right_idx < LW'(count_ff);
      stat.child_gt  = left_gt || right_gt;
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.do_insert) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.do_remove) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // Request latch, hole index, moving value and root mirror.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         is_remove_ff <= req_command;
         val_ff       <= req_value;
         status_ff    <= STATUS_OK;
      end else if (cmd.load_last) begin
         val_ff <= rd_val;
      end
      if (cmd.set_full) begin
         status_ff <= STATUS_FULL;
      end else if (cmd.set_empty) begin
         status_ff <= STATUS_EMPTY;
      end
      if (cmd.do_insert) begin
         pos_ff <= AW'(count_ff);
      end else if (cmd.up_move) begin
         pos_ff <= parent_idx;
      end else if (cmd.load_last) begin
         pos_ff <= '0;
      end else if (cmd.down_move) begin
         pos_ff <= child_idx;
      end
      if (cmd.cap_left) begin
         left_val_ff <= rd_val;
         right_ok_ff <= stat.right_ok;
      end
      if (wr_en && pos_ff == '0) begin
         top_ff <= wr_data;
      end
   end

   // Response register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response register payload.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_top_ff    <= (count_ff == '0) ? '0 : top_ff;
         out_count_ff  <= COUNT_OUT_W'(count_ff);
         out_empty_ff  <= count_ff == '0;
         out_status_ff <= status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = out_top_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_is_empty    = out_empty_ff;
   assign rsp_status      = out_status_ff;

   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // The count moves only on an insert or remove command.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_insert || cmd.do_remove) |=> $stable(count_ff))
      else $error("entry count changed without a command");

   // A response is loaded only when the response register is free.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending response overwritten");

endmodule

@@ design/binary_max_heap_queue.sv @@
// Top level of the binary max-heap priority queue.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_dp (which holds bmhq_ram).
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_command, req_value
//   rsp_      out        rsp_valid / rsp_stall  rsp_top_value, rsp_entry_count,
//                                               rsp_is_empty, rsp_status
//
// One request is processed at a time. An insert reads one parent for each level that the
// value rises, until it ends at the root or below a parent that it does not beat; a remove
// takes the last entry as the moving value at the root and reads the children for each
// level that it sinks. A refused request or the removal of the last entry does no sift walk.
// The pace of the walk is set by the single read port of the entry RAM and its registered
// read, which the sift walk uses once per parent and twice per child pair.
// Synchronous reset empties the heap at once; the RAM itself needs no clearing.
// A stalled response stays in the output register while the next request is
// already being worked on; that request completes once the register frees up.
module binary_max_heap_queue
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = BMHQ_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_top_value,
   output logic [COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic [1:0]               rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bmhq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_command),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_top_value   (rsp_top_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

endmodule
